### hdl/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every rising edge outside reset.
`define DQ_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Check that a condition in one cycle implies another in the same cycle.
`define DQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define DQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/dq_pkg.sv
// Types and constants shared by the deque cells, tree, top level and checker.
`default_nettype none

package dq_pkg;

    localparam int DEPTH_DEF      = 256;
    localparam int DATA_WIDTH_DEF = 64;

    // Item field layout
    localparam int OP_W        = 3;
    localparam int VALUE_W     = 64;
    localparam int CNT_FIELD_W = 9;
    localparam int VALUE_LSB   = OP_W;
    localparam int OK_BIT      = VALUE_W;
    localparam int CNT_LSB     = VALUE_W + 1;
    localparam int S_TDATA_W   = 72;
    localparam int M_TDATA_W   = 80;

    // OR levels between two register ranks of the back-select tree
    localparam int TREE_SPAN = 3;

    typedef logic [VALUE_W-1:0]     value_t;
    typedef logic [CNT_FIELD_W-1:0] cnt_field_t;
    typedef logic [M_TDATA_W-1:0]   m_word_t;

    typedef enum logic [OP_W-1:0] {
        OP_PEEK_BACK  = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_BACK   = 3'd2,
        OP_PUSH_FRONT = 3'd3,
        OP_POP_FRONT  = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WAIT,
        ST_HOLD
    } state_t;

    // Per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic push_front;
        logic pop_front;
        logic push_back;
    } cell_ctl_t;

endpackage

`default_nettype wire

### hdl/dq_cell.sv
// One storage cell of the deque chain.
`default_nettype none

module dq_cell #(
    parameter int DW  = dq_pkg::DATA_WIDTH_DEF,
    parameter int CW  = $clog2(dq_pkg::DEPTH_DEF + 1),
    parameter int IDX = 0
) (
    input  wire                    clk,
    input  wire dq_pkg::cell_ctl_t ctl,
    input  wire [CW-1:0]           count,
    input  wire [DW-1:0]           push_value,
    input  wire [DW-1:0]           lower_data,
    input  wire [DW-1:0]           upper_data,
    output logic [DW-1:0]          data,
    output logic [DW-1:0]          leaf
);

    logic [DW-1:0] data_reg;
    logic [DW-1:0] data_next;

    // Push front moves every entry one cell up, pop front one cell down,
    // push back fills only the first free cell.
    always_comb
    begin
        data_next = data_reg;
        priority if (ctl.push_front)
        begin
            data_next = lower_data;
        end
        else if (ctl.pop_front)
        begin
            data_next = upper_data;
        end
        else if (ctl.push_back && (count == CW'(IDX)))
        begin
            data_next = push_value;
        end
        else
        begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

    // Offer the entry to the select tree only when this cell holds the back.
    assign leaf = (count == CW'(IDX + 1)) ? data_reg : '0;

endmodule

`default_nettype wire

### hdl/dq_tree.sv
// Pipelined OR tree that brings the back entry of the chain to one port.
`default_nettype none

module dq_tree #(
    parameter int DEPTH = dq_pkg::DEPTH_DEF,
    parameter int DW    = dq_pkg::DATA_WIDTH_DEF
) (
    input  wire           clk,
    input  wire [DW-1:0]  leaf [DEPTH],
    output logic [DW-1:0] root
);

    localparam int LOG = $clog2(DEPTH);
    localparam int P2  = 1 << LOG;

    logic [DW-1:0] node [1:2*P2-1];

    for (genvar i = 0; i < P2; i++)
    begin : g_leaf
        if (i < DEPTH)
        begin : g_used
            assign node[P2 + i] = leaf[i];
        end
        else
        begin : g_pad
            assign node[P2 + i] = '0;
        end
    end

    for (genvar n = 1; n < P2; n++)
    begin : g_node
        localparam int LVL  = $clog2(n + 1) - 1;
        localparam bit REGD = ((LOG - LVL) % dq_pkg::TREE_SPAN) == 0;
        if (REGD)
        begin : g_reg
            logic [DW-1:0] sum_reg;
            logic [DW-1:0] sum_next;
            assign sum_next = node[2*n] | node[2*n + 1];
            always_ff @(posedge clk)
            begin
                sum_reg <= sum_next;
            end
            assign node[n] = sum_reg;
        end
        else
        begin : g_comb
            assign node[n] = node[2*n] | node[2*n + 1];
        end
    end

    assign root = node[1];

endmodule

`default_nettype wire

### hdl/double_ended_queue_unit.sv
// Top level of the bounded double-ended queue built as a chain of cells.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | op[2:0], push_value[66:3], zero pad
//  m_*     | out | m_tvalid/m_tready  | read_value[63:0], ok[64],
//          |     |                    | entry_count[73:65], zero pad
//
// Pushes, pop front, unknown ops and any op on an empty queue are answered
// without a wait state. Peek back and pop back on a non-empty queue first
// wait in ST_WAIT for the registered OR tree that selects the back cell of
// the chain, when that tree holds any register rank.
// Reset clears the entry count, the control state and the output valid;
// the cells keep whatever they hold and are never read before written.
// While the output is stalled one more item is accepted into a hold
// register, then s_tready drops until the output drains.
`default_nettype none

module double_ended_queue_unit #(
    parameter int DEPTH      = dq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           s_tvalid,
    output logic                          s_tready,
    input  wire [dq_pkg::S_TDATA_W-1:0]   s_tdata,  // op, push_value, pad
    output logic                          m_tvalid,
    input  wire                           m_tready,
    output logic [dq_pkg::M_TDATA_W-1:0]  m_tdata   // read_value, ok, entry_count, pad
);

    localparam int CW       = $clog2(DEPTH + 1);
    localparam int TREE_LAT = $clog2(DEPTH) / dq_pkg::TREE_SPAN;
    localparam int WW       = (TREE_LAT > 1) ? $clog2(TREE_LAT) : 1;

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    dq_pkg::state_t           state_reg, state_next;
    logic [CW-1:0]            count_reg, count_next;
    logic [WW-1:0]            wait_reg, wait_next;
    logic [dq_pkg::OP_W-1:0]  op_reg, op_next;
    dq_pkg::m_word_t          hold_reg, hold_next;
    dq_pkg::m_word_t          m_data_reg, m_data_next;
    logic                     m_valid_reg, m_valid_next;

    // ------------------------------------------------------------------
    // Input unpacking
    // ------------------------------------------------------------------
    logic [dq_pkg::OP_W-1:0]  s_op;
    logic [DATA_WIDTH-1:0]    push_val;

    assign s_op     = s_tdata[dq_pkg::OP_W-1:0];
    assign push_val = DATA_WIDTH'(s_tdata[dq_pkg::VALUE_LSB +: dq_pkg::VALUE_W]);

    // ------------------------------------------------------------------
    // Chain of cells and back-select tree
    // ------------------------------------------------------------------
    dq_pkg::cell_ctl_t        cell_ctl;
    logic [DATA_WIDTH-1:0]    cell_data [DEPTH];
    logic [DATA_WIDTH-1:0]    cell_leaf [DEPTH];
    logic [DATA_WIDTH-1:0]    back_data;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] lower_w;
        logic [DATA_WIDTH-1:0] upper_w;

        if (i == 0)
        begin : g_first
            assign lower_w = push_val;
        end
        else
        begin : g_lower
            assign lower_w = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign upper_w = '0;
        end
        else
        begin : g_upper
            assign upper_w = cell_data[i+1];
        end

        dq_cell #(
            .DW  (DATA_WIDTH),
            .CW  (CW),
            .IDX (i)
        ) u_cell (
            .clk        (clk),
            .ctl        (cell_ctl),
            .count      (count_reg),
            .push_value (push_val),
            .lower_data (lower_w),
            .upper_data (upper_w),
            .data       (cell_data[i]),
            .leaf       (cell_leaf[i])
        );
    end

    dq_tree #(
        .DEPTH (DEPTH),
        .DW    (DATA_WIDTH)
    ) u_tree (
        .clk  (clk),
        .leaf (cell_leaf),
        .root (back_data)
    );

    // ------------------------------------------------------------------
    // Operation decode
    // ------------------------------------------------------------------
    logic                     acc;
    logic                     can_load;
    logic                     empty;
    logic                     full;
    logic [dq_pkg::OP_W-1:0]  cur_op;
    logic                     start_wait;
    logic                     wait_done;
    logic                     fin;
    logic                     ok_c;
    logic [DATA_WIDTH-1:0]    rd_c;
    logic [CW-1:0]            count_after;
    dq_pkg::m_word_t          res_c;

    assign acc      = s_tvalid && s_tready;
    assign can_load = !m_valid_reg || m_tready;
    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CW'(DEPTH));
    assign cur_op   = (state_reg == dq_pkg::ST_WAIT) ? op_reg : s_op;

    // A back read on a non-empty queue waits for the tree to settle.
    assign start_wait = acc && !empty && (TREE_LAT != 0) &&
                        ((s_op == dq_pkg::OP_PEEK_BACK) || (s_op == dq_pkg::OP_POP_BACK));
    assign wait_done  = (state_reg == dq_pkg::ST_WAIT) && (wait_reg == '0);
    assign fin        = (acc && !start_wait) || wait_done;

    always_comb
    begin
        ok_c        = 1'b0;
        rd_c        = '0;
        count_after = count_reg;
        cell_ctl    = '0;
        unique case (cur_op)
            dq_pkg::OP_PEEK_BACK:
            begin
                ok_c = !empty;
                rd_c = back_data;
            end
            dq_pkg::OP_PUSH_BACK:
            begin
                ok_c               = !full;
                cell_ctl.push_back = fin && ok_c;
                count_after        = ok_c ? count_reg + CW'(1) : count_reg;
            end
            dq_pkg::OP_POP_BACK:
            begin
                ok_c        = !empty;
                rd_c        = back_data;
                count_after = ok_c ? count_reg - CW'(1) : count_reg;
            end
            dq_pkg::OP_PUSH_FRONT:
            begin
                ok_c                = !full;
                cell_ctl.push_front = fin && ok_c;
                count_after         = ok_c ? count_reg + CW'(1) : count_reg;
            end
            dq_pkg::OP_POP_FRONT:
            begin
                ok_c               = !empty;
                rd_c               = cell_data[0];
                cell_ctl.pop_front = fin && ok_c;
                count_after        = ok_c ? count_reg - CW'(1) : count_reg;
            end
            default:
            begin
                ok_c = 1'b0;
            end
        endcase
        // Drop the read value on any failed op.
        if (!ok_c)
        begin
            rd_c = '0;
        end
    end

    always_comb
    begin
        res_c = '0;
        res_c[dq_pkg::VALUE_W-1:0]                    = dq_pkg::value_t'(rd_c);
        res_c[dq_pkg::OK_BIT]                         = ok_c;
        res_c[dq_pkg::CNT_LSB +: dq_pkg::CNT_FIELD_W] = dq_pkg::cnt_field_t'(count_after);
    end

    // ------------------------------------------------------------------
    // State machine: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dq_pkg::ST_IDLE:
            begin
                if (start_wait)
                begin
                    state_next = dq_pkg::ST_WAIT;
                end
                else if (acc && !can_load)
                begin
                    state_next = dq_pkg::ST_HOLD;
                end
            end
            dq_pkg::ST_WAIT:
            begin
                if (wait_done)
                begin
                    state_next = can_load ? dq_pkg::ST_IDLE : dq_pkg::ST_HOLD;
                end
            end
            dq_pkg::ST_HOLD:
            begin
                if (can_load)
                begin
                    state_next = dq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dq_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // State machine: outputs and datapath next values
    // ------------------------------------------------------------------
    always_comb
    begin
        s_tready     = (state_reg == dq_pkg::ST_IDLE);
        count_next   = fin ? count_after : count_reg;
        op_next      = acc ? s_op : op_reg;
        wait_next    = wait_reg;
        hold_next    = hold_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        if (start_wait)
        begin
            wait_next = WW'(TREE_LAT - 1);
        end
        else if ((state_reg == dq_pkg::ST_WAIT) && !wait_done)
        begin
            wait_next = wait_reg - WW'(1);
        end

        if (m_tready)
        begin
            m_valid_next = 1'b0;
        end

        if (state_reg == dq_pkg::ST_HOLD)
        begin
            if (can_load)
            begin
                m_valid_next = 1'b1;
                m_data_next  = hold_reg;
            end
        end
        else if (fin)
        begin
            if (can_load)
            begin
                m_valid_next = 1'b1;
                m_data_next  = res_c;
            end
            else
            begin
                hold_next = res_c;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= dq_pkg::ST_IDLE;
            count_reg   <= '0;
            wait_reg    <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            wait_reg    <= wait_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers: no reset needed
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        hold_reg   <= hold_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire

### hdl/dq_checker.sv
// Port-level checks for the double-ended queue, bound to its top level.
`default_nettype none
`include "assert_macros.svh"

module dq_checker #(
    parameter int DEPTH = dq_pkg::DEPTH_DEF
) (
    input wire                          clk,
    input wire                          rst_n,
    input wire                          s_tvalid,
    input wire                          s_tready,
    input wire [dq_pkg::S_TDATA_W-1:0]  s_tdata,
    input wire                          m_tvalid,
    input wire                          m_tready,
    input wire [dq_pkg::M_TDATA_W-1:0]  m_tdata
);

    logic                           res_ok;
    logic [dq_pkg::VALUE_W-1:0]     res_value;
    logic [dq_pkg::CNT_FIELD_W-1:0] res_count;
    logic [dq_pkg::OP_W-1:0]        in_op;
    logic                           unknown_in;

    assign res_ok     = m_tdata[dq_pkg::OK_BIT];
    assign res_value  = m_tdata[dq_pkg::VALUE_W-1:0];
    assign res_count  = m_tdata[dq_pkg::CNT_LSB +: dq_pkg::CNT_FIELD_W];
    assign in_op      = s_tdata[dq_pkg::OP_W-1:0];
    assign unknown_in = s_tvalid && s_tready && (in_op > dq_pkg::OP_POP_FRONT);

    // A stalled result stays put.
    `DQ_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // A failed op never carries a value.
    `DQ_ASSERT_SAME(a_fail_zero, m_tvalid && !res_ok, res_value == '0, "failed op returned nonzero value")

    // Count never goes past the capacity while it fits the field.
    `DQ_ASSERT_SAME(a_count_cap, m_tvalid, (DEPTH > 511) || (res_count <= DEPTH), "entry count beyond capacity")

    // An item taken during an output stall drops s_tready.
    `DQ_ASSERT_NEXT(a_hold_full, m_tvalid && !m_tready && s_tvalid && s_tready, !s_tready, "second item accepted during stall")

    // An unknown op taken while the output is free leaves a failed result next cycle.
    `DQ_ASSERT_NEXT(a_unknown_fail, unknown_in && (!m_tvalid || m_tready), m_tvalid && !res_ok, "unknown op succeeded")

endmodule

bind double_ended_queue_unit dq_checker #(.DEPTH(DEPTH)) u_dq_checker (.*);

`default_nettype wire

### bench/double_ended_queue_unit_tb.sv
// Self-checking bench for the bounded double-ended queue: directed and random op streams vs. a ring model.
module double_ended_queue_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dq_pkg::*;

    localparam int RING_DEPTH   = DEPTH_DEF;
    localparam int RING_IDX_W   = $clog2(RING_DEPTH);
    localparam int ITEM_TARGET  = 1850;
    localparam int QUIET_LIMIT  = 4000;   // cycles with no handshake on either side
    localparam int TAIL_CYCLES  = 8;      // idle margin after the last answer

    // Fields of one result item, as the model expects them
    typedef struct packed {
        value_t     read_value;
        logic       ok;
        cnt_field_t entry_count;
    } deque_answer_t;

    typedef enum {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN
    } op_mix_t;

    // Ring model of the queue plus the list of answers still owed by the block
    class deque_scoreboard;
        value_t                slots [RING_DEPTH];
        bit [RING_IDX_W-1:0]   front_slot;
        bit [RING_IDX_W-1:0]   back_slot;
        cnt_field_t            fill;
        deque_answer_t         awaited [$];
        int                    mismatches;

        function new();
            front_slot = '0;
            back_slot  = '0;
            fill       = '0;
            mismatches = 0;
        endfunction

        function int held();
            return fill;
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction

        // Apply one accepted op to the model and queue the answer it owes
        function void note_input(logic [OP_W-1:0] code, value_t value);
            deque_answer_t ans;
            ans = '0;
            case (code)
                OP_PEEK_BACK:
                    if (fill != 0)
                    begin
                        ans.read_value = slots[back_slot - 1'b1];
                        ans.ok = 1'b1;
                    end
                OP_PUSH_BACK:
                    if (fill < RING_DEPTH)
                    begin
                        slots[back_slot] = value;
                        back_slot++;
                        fill++;
                        ans.ok = 1'b1;
                    end
                OP_POP_BACK:
                    if (fill != 0)
                    begin
                        back_slot--;
                        ans.read_value = slots[back_slot];
                        fill--;
                        ans.ok = 1'b1;
                    end
                OP_PUSH_FRONT:
                    if (fill < RING_DEPTH)
                    begin
                        front_slot--;
                        slots[front_slot] = value;
                        fill++;
                        ans.ok = 1'b1;
                    end
                OP_POP_FRONT:
                    if (fill != 0)
                    begin
                        ans.read_value = slots[front_slot];
                        front_slot++;
                        fill--;
                        ans.ok = 1'b1;
                    end
                default:
                    ;   // unknown op: no change, no success
            endcase
            ans.entry_count = fill;
            awaited.push_back(ans);
        endfunction

        // Compare one accepted result item against the oldest owed answer
        function void check_result(m_word_t word);
            deque_answer_t want;
            value_t        got_value;
            logic          got_ok;
            cnt_field_t    got_count;
            got_value = word[VALUE_W-1:0];
            got_ok    = word[OK_BIT];
            got_count = word[CNT_LSB +: CNT_FIELD_W];
            if (awaited.size() == 0)
            begin
                $display("%0t: result %h arrived with no answer owed", $time, word);
                mismatches++;
                return;
            end
            want = awaited.pop_front();
            if (got_value !== want.read_value)
            begin
                $display("%0t: read_value mismatch, expected %h got %h",
                         $time, want.read_value, got_value);
                mismatches++;
            end
            if (got_ok !== want.ok)
            begin
                $display("%0t: ok mismatch, expected %b got %b", $time, want.ok, got_ok);
                mismatches++;
            end
            if (got_count !== want.entry_count)
            begin
                $display("%0t: entry_count mismatch, expected %0d got %0d",
                         $time, want.entry_count, got_count);
                mismatches++;
            end
        endfunction
    endclass

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;

    deque_scoreboard       sb = new();
    int                    items_sent   = 0;
    bit                    send_gaps    = 1'b1;
    bit                    recv_stalls  = 1'b1;
    int                    stall_left   = 0;

    double_ended_queue_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one
    function automatic int gap_length();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic value_t pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return '0;
        if (r < 10)
            return '1;
        return {$urandom, $urandom};
    endfunction

    // Fill leans on pushes, drain on pops; a few unknown codes everywhere
    function automatic logic [OP_W-1:0] pick_op(op_mix_t mix);
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)
            return OP_W'($urandom_range(5, 7));
        r = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:
            begin
                if (r < 40) return OP_PUSH_BACK;
                if (r < 75) return OP_PUSH_FRONT;
                if (r < 82) return OP_POP_BACK;
                if (r < 89) return OP_POP_FRONT;
                return OP_PEEK_BACK;
            end
            MIX_DRAIN:
            begin
                if (r < 10) return OP_PUSH_BACK;
                if (r < 18) return OP_PUSH_FRONT;
                if (r < 48) return OP_POP_BACK;
                if (r < 82) return OP_POP_FRONT;
                return OP_PEEK_BACK;
            end
            default:
            begin
                if (r < 24) return OP_PUSH_BACK;
                if (r < 48) return OP_PUSH_FRONT;
                if (r < 66) return OP_POP_BACK;
                if (r < 84) return OP_POP_FRONT;
                return OP_PEEK_BACK;
            end
        endcase
    endfunction

    // Either side may run without idling for a whole phase
    function automatic void shuffle_idling();
        send_gaps   = ($urandom_range(0, 99) < 70);
        recv_stalls = ($urandom_range(0, 99) < 70);
    endfunction

    // Offer one item, hold it until accepted, then note it in the model
    task automatic send_item(logic [OP_W-1:0] code, value_t value);
        int gap;
        gap = 0;
        if (send_gaps && $urandom_range(0, 99) < 35)
            gap = gap_length();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({value, code});
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_input(code, value);
        items_sent++;
    endtask

    // Drop valid and wait until every owed answer has come back
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0) @(posedge clk);
    endtask

    // Receiver: ready most of the time, stalls of random length when enabled
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (stall_left != 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (recv_stalls && $urandom_range(0, 99) < 25)
        begin
            m_tready   <= 1'b0;
            stall_left <= gap_length() - 1;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // Watchdog: end the run when no handshake happens for too long
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        @(posedge rst_n);
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("FAIL");
        $finish;
    end

    initial
    begin
        bit paused;
        paused = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reads on empty, unknown codes, extremes of the value, wrap of both ends
        send_item(OP_PEEK_BACK,  '0);
        send_item(OP_POP_BACK,   '1);
        send_item(OP_POP_FRONT,  '1);
        send_item(3'd5,          '1);
        send_item(3'd6,          '1);
        send_item(3'd7,          '1);
        send_item(OP_PUSH_BACK,  '1);
        send_item(OP_PUSH_FRONT, '0);
        send_item(OP_PUSH_BACK,  64'h8000_0000_0000_0001);
        send_item(OP_PUSH_FRONT, 64'hAAAA_5555_AAAA_5555);
        send_item(3'd7,          64'h5555_AAAA_5555_AAAA);
        send_item(OP_PEEK_BACK,  '1);
        send_item(OP_POP_FRONT,  '0);
        send_item(OP_POP_BACK,   '0);
        send_item(OP_PEEK_BACK,  '0);
        send_item(OP_POP_BACK,   '0);
        send_item(OP_POP_FRONT,  '0);
        send_item(OP_PEEK_BACK,  '0);
        send_item(OP_POP_FRONT,  '0);
        send_item(OP_PUSH_FRONT, 64'h0123_4567_89AB_CDEF);
        send_item(OP_POP_BACK,   '0);

        // Random: fill to full and beyond, drain to empty and beyond, on the first pass wait until
        // every answer is back, then a mixed stretch; stop wherever the item budget runs out
        while (items_sent < ITEM_TARGET)
        begin
            shuffle_idling();
            while ((sb.held() < RING_DEPTH) && (items_sent < ITEM_TARGET))
                send_item(pick_op(MIX_FILL), pick_value());
            repeat (20)
                if (items_sent < ITEM_TARGET)
                    send_item(pick_op(MIX_FILL), pick_value());

            shuffle_idling();
            while ((sb.held() != 0) && (items_sent < ITEM_TARGET))
                send_item(pick_op(MIX_DRAIN), pick_value());
            repeat (15)
                if (items_sent < ITEM_TARGET)
                    send_item(pick_op(MIX_DRAIN), pick_value());

            if (!paused)
            begin
                hold_until_drained();
                paused = 1'b1;
            end

            shuffle_idling();
            repeat (80)
                if (items_sent < ITEM_TARGET)
                    send_item(pick_op(MIX_EVEN), pick_value());
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sb.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
